### sv/pal_pkg.sv
// Shared constants, codes and controller/datapath link types for the PA learner.
`default_nettype none
package pal_pkg;

  localparam int DIM     = 64;
  localparam int IDX_W   = $clog2(DIM + 1);
  localparam int ADDR_W  = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int FEAT_W  = 16;
  localparam int WGT_W   = 32;
  localparam int PROD_W  = FEAT_W + WGT_W;
  localparam int SQ_W    = 2 * FEAT_W;
  localparam int DOT_W   = 64;
  localparam int NORM_W  = 48;
  localparam int CFG_W   = 24;
  localparam int CNT_W   = 32;
  localparam int NUM_CNT = 5;
  localparam int RAND_W  = 16;
  localparam int TAU_W   = 47;
  localparam int DEN_W   = NORM_W + 1;
  localparam int REM_W   = DEN_W + 1;
  localparam int LOSS_W  = 64;
  localparam int DIV_SH  = 24;
  localparam int OVF_SH  = TAU_W - DIV_SH;
  localparam int DCNT_W  = $clog2(TAU_W + 1);
  localparam int QS_W    = 41;
  localparam int QP_W    = QS_W + RAND_W;
  localparam int UPROD_W = TAU_W + FEAT_W;
  localparam int MAG_W   = UPROD_W - DIV_SH;
  localparam int UPSUM_W = MAG_W + 2;
  localparam int ADDR_BITS = 5;

  localparam int CNT_TP = 0;
  localparam int CNT_TN = 1;
  localparam int CNT_FP = 2;
  localparam int CNT_FN = 3;
  localparam int CNT_QT = 4;

  localparam logic CMD_ELEM  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  localparam logic [1:0] UR_PA  = 2'd0;
  localparam logic [1:0] UR_PA1 = 2'd1;
  localparam logic [1:0] UR_PA2 = 2'd2;

  localparam logic [1:0] QR_ALWAYS = 2'd0;
  localparam logic [1:0] QR_MARGIN = 2'd1;
  localparam logic [1:0] QR_FIXED  = 2'd2;

  localparam logic [2:0] REG_UPDATE_RULE = 3'd0;
  localparam logic [2:0] REG_QUERY_RULE  = 3'd1;
  localparam logic [2:0] REG_QUERY_BIAS  = 3'd2;
  localparam logic [2:0] REG_AGGR        = 3'd3;
  localparam logic [2:0] REG_SMO         = 3'd4;

  typedef struct packed {
    logic elem;
    logic clear;
    logic decide;
    logic qcheck;
    logic div_init;
    logic div_step;
    logic clip;
    logic upd_issue;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic skip;
    logic query;
    logic loss_pos;
    logic div_done;
    logic upd_done;
  } dp_stat_t;

endpackage
`default_nettype wire

### sv/passive_aggressive_active_learner.sv
// Top level of the passive-aggressive online classifier with selective label queries.
//
// Feature elements stream in one per clock, a beat being taken whenever start is high and
// busy is low; each element is buffered, its product with the stored weight and its square
// are accumulated through a two-stage multiply pipe. On the element marked last the block
// goes busy: it waits for the pipe to drain, then forms the prediction and updates the
// confusion counters and, unless the sample is skipped, decides the query. When the sample
// is queried and its loss is positive, a step then runs a restoring divider (a load step,
// one shift per quotient bit and a finishing step, or no shifts when the quotient
// saturates) and a clip step, followed by one pass over the received elements, one weight
// per cycle through the weight memory, until the update pipe has emptied.
// The result is shown for exactly one cycle with result_valid_o and cannot be held off;
// busy is high in that cycle. A clear beat (cmd_i high) zeroes weights and counters at
// once and yields no result.
// Registers sit on the APB port at byte addresses 0 (update_rule), 4 (query_rule),
// 8 (query_bias), 12 (aggressiveness) and 16 (soft_margin_offset); write them only
// while idle. No clearing pass is needed after reset.
`default_nettype none
module passive_aggressive_active_learner (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic        [pal_pkg::ADDR_BITS-1:0] paddr,
  input  wire logic        [31:0]                  pwdata,
  output logic             [31:0]                  prdata,
  output logic                                     pready,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic                                cmd_i,
  input  wire logic signed [pal_pkg::FEAT_W-1:0]   feature_i,
  input  wire logic                                label_i,
  input  wire logic        [pal_pkg::RAND_W-1:0]   random_value_i,
  input  wire logic                                last_element_i,
  output logic                                     result_valid_o,
  output logic                                     predicted_label_o,
  output logic                                     queried_o,
  output logic                                     updated_o,
  output logic                                     skipped_o,
  output logic             [pal_pkg::CNT_W-1:0]    true_positives_o,
  output logic             [pal_pkg::CNT_W-1:0]    true_negatives_o,
  output logic             [pal_pkg::CNT_W-1:0]    false_positives_o,
  output logic             [pal_pkg::CNT_W-1:0]    false_negatives_o,
  output logic             [pal_pkg::CNT_W-1:0]    query_total_o
);

  logic [1:0]                update_rule_q, query_rule_q;
  logic [pal_pkg::CFG_W-1:0] query_bias_q, aggr_q, smo_q;
  logic                      wr_en;
  logic [2:0]                reg_idx;

  pal_pkg::ctrl_cmd_t ctrl_cmd;
  pal_pkg::dp_stat_t  dp_stat;

  assign pready  = 1'b1;
  assign reg_idx = paddr[pal_pkg::ADDR_BITS-1:2];
  // register beat completes in the access phase
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      update_rule_q <= pal_pkg::UR_PA;
      query_rule_q  <= pal_pkg::QR_ALWAYS;
      query_bias_q  <= 24'd65536;
      aggr_q        <= 24'd65536;
      smo_q         <= 24'd32768;
    end else if (wr_en) begin
      unique case (reg_idx)
        pal_pkg::REG_UPDATE_RULE: update_rule_q <= pwdata[1:0];
        pal_pkg::REG_QUERY_RULE:  query_rule_q  <= pwdata[1:0];
        pal_pkg::REG_QUERY_BIAS:  query_bias_q  <= pwdata[pal_pkg::CFG_W-1:0];
        pal_pkg::REG_AGGR:        aggr_q        <= pwdata[pal_pkg::CFG_W-1:0];
        pal_pkg::REG_SMO:         smo_q         <= pwdata[pal_pkg::CFG_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      pal_pkg::REG_UPDATE_RULE: prdata = 32'(update_rule_q);
      pal_pkg::REG_QUERY_RULE:  prdata = 32'(query_rule_q);
      pal_pkg::REG_QUERY_BIAS:  prdata = 32'(query_bias_q);
      pal_pkg::REG_AGGR:        prdata = 32'(aggr_q);
      pal_pkg::REG_SMO:         prdata = 32'(smo_q);
      default:                  prdata = '0;
    endcase
  end

  pal_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .cmd_i          (cmd_i),
    .last_element_i (last_element_i),
    .stat_i         (dp_stat),
    .cmd_o          (ctrl_cmd),
    .busy           (busy)
  );

  pal_dp u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (ctrl_cmd),
    .stat_o               (dp_stat),
    .feature_i            (feature_i),
    .label_i              (label_i),
    .random_value_i       (random_value_i),
    .update_rule_i        (update_rule_q),
    .query_rule_i         (query_rule_q),
    .query_bias_i         (query_bias_q),
    .aggressiveness_i     (aggr_q),
    .soft_margin_offset_i (smo_q),
    .result_valid_o       (result_valid_o),
    .predicted_label_o    (predicted_label_o),
    .queried_o            (queried_o),
    .updated_o            (updated_o),
    .skipped_o            (skipped_o),
    .true_positives_o     (true_positives_o),
    .true_negatives_o     (true_negatives_o),
    .false_positives_o    (false_positives_o),
    .false_negatives_o    (false_negatives_o),
    .query_total_o        (query_total_o)
  );

endmodule
`default_nettype wire

### sv/pal_ctrl.sv
// Sequencing state machine for the PA learner.
`default_nettype none
module pal_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  input  wire logic                cmd_i,
  input  wire logic                last_element_i,
  input  wire pal_pkg::dp_stat_t   stat_i,
  output pal_pkg::ctrl_cmd_t       cmd_o,
  output logic                     busy
);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_DRAIN   = 9'b000000010,
    S_DECIDE  = 9'b000000100,
    S_QCHECK  = 9'b000001000,
    S_DIVINIT = 9'b000010000,
    S_DIV     = 9'b000100000,
    S_CLIP    = 9'b001000000,
    S_UPD     = 9'b010000000,
    S_DONE    = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   beat;

  assign busy = (state_q != S_IDLE);
  assign beat = start && !busy;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.elem  = beat && (cmd_i == pal_pkg::CMD_ELEM);
        cmd_o.clear = beat && (cmd_i == pal_pkg::CMD_CLEAR);
        if (cmd_o.elem && last_element_i) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        if (!stat_i.pipe_busy) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d = stat_i.skip ? S_DONE : S_QCHECK;
      end
      S_QCHECK: begin
        cmd_o.qcheck = 1'b1;
        state_d = (stat_i.query && stat_i.loss_pos) ? S_DIVINIT : S_DONE;
      end
      S_DIVINIT: begin
        cmd_o.div_init = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = !stat_i.div_done;
        if (stat_i.div_done) state_d = S_CLIP;
      end
      S_CLIP: begin
        cmd_o.clip = 1'b1;
        state_d = S_UPD;
      end
      S_UPD: begin
        cmd_o.upd_issue = 1'b1;
        if (stat_i.upd_done) state_d = S_DONE;
      end
      S_DONE: begin
        cmd_o.finish = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

endmodule
`default_nettype wire

### sv/pal_dp.sv
// Datapath: sample and weight memories, accumulators, divider, update pipe, counters.
`default_nettype none
module pal_dp (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire pal_pkg::ctrl_cmd_t                  cmd_i,
  output pal_pkg::dp_stat_t                        stat_o,
  input  wire logic signed [pal_pkg::FEAT_W-1:0]   feature_i,
  input  wire logic                                label_i,
  input  wire logic        [pal_pkg::RAND_W-1:0]   random_value_i,
  input  wire logic        [1:0]                   update_rule_i,
  input  wire logic        [1:0]                   query_rule_i,
  input  wire logic        [pal_pkg::CFG_W-1:0]    query_bias_i,
  input  wire logic        [pal_pkg::CFG_W-1:0]    aggressiveness_i,
  input  wire logic        [pal_pkg::CFG_W-1:0]    soft_margin_offset_i,
  output logic                                     result_valid_o,
  output logic                                     predicted_label_o,
  output logic                                     queried_o,
  output logic                                     updated_o,
  output logic                                     skipped_o,
  output logic             [pal_pkg::CNT_W-1:0]    true_positives_o,
  output logic             [pal_pkg::CNT_W-1:0]    true_negatives_o,
  output logic             [pal_pkg::CNT_W-1:0]    false_positives_o,
  output logic             [pal_pkg::CNT_W-1:0]    false_negatives_o,
  output logic             [pal_pkg::CNT_W-1:0]    query_total_o
);

  localparam int DIM = pal_pkg::DIM;

  // memories
  logic signed [pal_pkg::FEAT_W-1:0] sbuf [DIM];
  logic signed [pal_pkg::WGT_W-1:0]  wmem [DIM];
  logic [DIM-1:0]                    wval_q;

  logic [pal_pkg::ADDR_W-1:0]        rd_addr;
  logic signed [pal_pkg::WGT_W-1:0]  wrd_q;
  logic                              wvr_q;
  logic signed [pal_pkg::FEAT_W-1:0] sx_q;
  logic signed [pal_pkg::WGT_W-1:0]  w_eff;

  // sample accumulation
  logic [pal_pkg::IDX_W-1:0]         idx_q;
  logic                              elem_en;
  logic                              v1_q, v2_q;
  logic signed [pal_pkg::FEAT_W-1:0] x1_q;
  logic signed [pal_pkg::PROD_W-1:0] prod_q;
  logic [pal_pkg::SQ_W-1:0]          sq_q;
  logic signed [pal_pkg::DOT_W-1:0]  dot_q;
  logic [pal_pkg::NORM_W-1:0]        norm_q;
  logic                              label_q;
  logic [pal_pkg::RAND_W-1:0]        r_q;

  // decision
  logic [pal_pkg::DOT_W-1:0]         absp;
  logic [pal_pkg::DEN_W-1:0]         qsum_full;
  logic [pal_pkg::QS_W-1:0]          qs;
  logic [pal_pkg::QP_W-1:0]          qprod_q;
  logic signed [pal_pkg::DOT_W+1:0]  lossx;
  logic [pal_pkg::LOSS_W-1:0]        loss_q;
  logic                              loss_pos_q;
  logic [pal_pkg::DEN_W-1:0]         den_q;
  logic                              query;
  logic                              pred_q, query_q, upd_q, skip_q;
  logic [pal_pkg::CNT_W-1:0]         cnt_q [pal_pkg::NUM_CNT];

  // divider
  logic [pal_pkg::REM_W-1:0]         rem_q, rem2;
  logic [pal_pkg::TAU_W-1:0]         nlow_q, quo_q, tau_q, clip_lim;
  logic [pal_pkg::DCNT_W-1:0]        dcnt_q;
  logic                              ovf, ge;

  // update pipe
  logic [pal_pkg::IDX_W-1:0]         ucnt_q;
  logic                              uiss;
  logic                              u1_q, u2_q, uneg_q;
  logic [pal_pkg::ADDR_W-1:0]        ua1_q, ua2_q;
  logic [pal_pkg::FEAT_W-1:0]        ax;
  logic [pal_pkg::UPROD_W-1:0]       uprod_q;
  logic signed [pal_pkg::WGT_W-1:0]  uw_q;
  logic signed [pal_pkg::UPSUM_W-1:0] umag, usum;
  logic signed [pal_pkg::WGT_W-1:0]  wnew;

  assign elem_en = cmd_i.elem && (idx_q < pal_pkg::IDX_W'(DIM));
  assign uiss    = cmd_i.upd_issue && (ucnt_q < idx_q);
  assign rd_addr = cmd_i.upd_issue ? ucnt_q[pal_pkg::ADDR_W-1:0]
                                   : idx_q[pal_pkg::ADDR_W-1:0];
  assign w_eff   = wvr_q ? wrd_q : '0;

  always_ff @(posedge clk_i) begin
    if (elem_en) sbuf[rd_addr] <= feature_i;
    if (u2_q)    wmem[ua2_q]   <= wnew;
    wrd_q <= wmem[rd_addr];
    sx_q  <= sbuf[rd_addr];
  end

  // decision logic
  always_comb begin
    absp      = dot_q[pal_pkg::DOT_W-1] ? (pal_pkg::DOT_W'(0) - pal_pkg::DOT_W'(dot_q))
                                        : pal_pkg::DOT_W'(dot_q);
    qsum_full = pal_pkg::DEN_W'(query_bias_i) + pal_pkg::DEN_W'(absp[pal_pkg::DOT_W-1:16]);
    qs        = (qsum_full >= (pal_pkg::DEN_W'(1) << 40)) ? (pal_pkg::QS_W'(1) << 40)
                                                          : qsum_full[pal_pkg::QS_W-1:0];
    lossx     = (pal_pkg::DOT_W+2)'(65'sh1_0000_0000)
              + (label_q ? -(pal_pkg::DOT_W+2)'(dot_q) : (pal_pkg::DOT_W+2)'(dot_q));
    unique case (query_rule_i)
      pal_pkg::QR_MARGIN: query = (query_bias_i != '0)
                                && (qprod_q <= pal_pkg::QP_W'({query_bias_i, 16'b0}));
      pal_pkg::QR_FIXED:  query = (pal_pkg::CFG_W'(r_q) <= query_bias_i);
      default:            query = 1'b1;
    endcase
  end

  // divider step and overflow test
  always_comb begin
    ovf  = ({8'b0, loss_q} >= {den_q, pal_pkg::OVF_SH'(0)});
    rem2 = {rem_q[pal_pkg::REM_W-2:0], nlow_q[pal_pkg::TAU_W-1]};
    ge   = (rem2 >= {1'b0, den_q});
    clip_lim = pal_pkg::TAU_W'({aggressiveness_i, 16'b0});
  end

  // weight update arithmetic
  always_comb begin
    ax   = sx_q[pal_pkg::FEAT_W-1] ? (pal_pkg::FEAT_W'(0) - pal_pkg::FEAT_W'(sx_q))
                                   : pal_pkg::FEAT_W'(sx_q);
    umag = $signed({2'b00, uprod_q[pal_pkg::UPROD_W-1:pal_pkg::DIV_SH]});
    usum = pal_pkg::UPSUM_W'(uw_q) + (uneg_q ? -umag : umag);
    if (usum > pal_pkg::UPSUM_W'(32'sh7FFF_FFFF))
      wnew = 32'sh7FFF_FFFF;
    else if (usum < -(pal_pkg::UPSUM_W'(33'sh0_8000_0000)))
      wnew = -32'sh7FFF_FFFF - 32'sd1;
    else
      wnew = usum[pal_pkg::WGT_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (elem_en) x1_q <= feature_i;
    prod_q <= pal_pkg::PROD_W'(x1_q) * pal_pkg::PROD_W'(w_eff);
    sq_q   <= pal_pkg::SQ_W'(pal_pkg::SQ_W'(x1_q) * pal_pkg::SQ_W'(x1_q));
    if (cmd_i.elem) begin
      label_q <= label_i;
      r_q     <= random_value_i;
    end
    if (cmd_i.decide) begin
      qprod_q    <= pal_pkg::QP_W'(r_q) * pal_pkg::QP_W'(qs);
      loss_q     <= lossx[pal_pkg::LOSS_W-1:0];
      loss_pos_q <= !lossx[pal_pkg::DOT_W+1] && (lossx != '0);
      den_q      <= (update_rule_i == pal_pkg::UR_PA2)
                  ? pal_pkg::DEN_W'(norm_q) + pal_pkg::DEN_W'({soft_margin_offset_i, 8'b0})
                  : pal_pkg::DEN_W'(norm_q);
    end
    if (cmd_i.div_init) begin
      rem_q  <= pal_pkg::REM_W'(loss_q[pal_pkg::LOSS_W-1:pal_pkg::OVF_SH]);
      nlow_q <= {loss_q[pal_pkg::OVF_SH-1:0], pal_pkg::DIV_SH'(0)};
      quo_q  <= ovf ? '1 : '0;
    end else if (cmd_i.div_step) begin
      rem_q  <= ge ? rem2 - {1'b0, den_q} : rem2;
      nlow_q <= nlow_q << 1;
      quo_q  <= {quo_q[pal_pkg::TAU_W-2:0], ge};
    end
    if (cmd_i.clip)
      tau_q <= ((update_rule_i == pal_pkg::UR_PA1) && (quo_q > clip_lim)) ? clip_lim : quo_q;
    ua1_q   <= rd_addr;
    ua2_q   <= ua1_q;
    uprod_q <= pal_pkg::UPROD_W'(tau_q) * pal_pkg::UPROD_W'(ax);
    uneg_q  <= sx_q[pal_pkg::FEAT_W-1] ^ ~label_q;
    uw_q    <= w_eff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wval_q <= '0;
      wvr_q  <= 1'b0;
      idx_q  <= '0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      dot_q  <= '0;
      norm_q <= '0;
      pred_q <= 1'b0;
      query_q <= 1'b0;
      upd_q  <= 1'b0;
      skip_q <= 1'b0;
      dcnt_q <= '0;
      ucnt_q <= '0;
      u1_q   <= 1'b0;
      u2_q   <= 1'b0;
      for (int k = 0; k < pal_pkg::NUM_CNT; k++) cnt_q[k] <= '0;
    end else begin
      wvr_q <= wval_q[rd_addr];
      v1_q  <= elem_en;
      v2_q  <= v1_q;
      u1_q  <= uiss;
      u2_q  <= u1_q;
      if (u2_q) wval_q[ua2_q] <= 1'b1;
      if (elem_en) idx_q <= idx_q + 1'b1;
      if (v2_q) begin
        dot_q  <= dot_q + pal_pkg::DOT_W'(prod_q);
        norm_q <= norm_q + pal_pkg::NORM_W'(sq_q);
      end
      if (cmd_i.decide) begin
        skip_q  <= (norm_q == '0);
        pred_q  <= (norm_q != '0) && !dot_q[pal_pkg::DOT_W-1];
        query_q <= 1'b0;
        upd_q   <= 1'b0;
        if (norm_q != '0) begin
          // confusion counters, saturating
          if (!dot_q[pal_pkg::DOT_W-1] == label_q) begin
            if (label_q) begin
              if (cnt_q[pal_pkg::CNT_TP] != '1) cnt_q[pal_pkg::CNT_TP] <= cnt_q[pal_pkg::CNT_TP] + 1'b1;
            end else begin
              if (cnt_q[pal_pkg::CNT_TN] != '1) cnt_q[pal_pkg::CNT_TN] <= cnt_q[pal_pkg::CNT_TN] + 1'b1;
            end
          end else if (!dot_q[pal_pkg::DOT_W-1]) begin
            if (cnt_q[pal_pkg::CNT_FP] != '1) cnt_q[pal_pkg::CNT_FP] <= cnt_q[pal_pkg::CNT_FP] + 1'b1;
          end else begin
            if (cnt_q[pal_pkg::CNT_FN] != '1) cnt_q[pal_pkg::CNT_FN] <= cnt_q[pal_pkg::CNT_FN] + 1'b1;
          end
        end
      end
      if (cmd_i.qcheck) begin
        query_q <= query;
        if (query && (cnt_q[pal_pkg::CNT_QT] != '1))
          cnt_q[pal_pkg::CNT_QT] <= cnt_q[pal_pkg::CNT_QT] + 1'b1;
      end
      if (cmd_i.div_init) begin
        upd_q  <= 1'b1;
        dcnt_q <= ovf ? '0 : pal_pkg::DCNT_W'(pal_pkg::TAU_W);
      end else if (cmd_i.div_step) begin
        dcnt_q <= dcnt_q - 1'b1;
      end
      if (cmd_i.clip) ucnt_q <= '0;
      else if (uiss)  ucnt_q <= ucnt_q + 1'b1;
      if (cmd_i.finish) begin
        idx_q  <= '0;
        dot_q  <= '0;
        norm_q <= '0;
      end
      if (cmd_i.clear) begin
        wval_q <= '0;
        idx_q  <= '0;
        v1_q   <= 1'b0;
        v2_q   <= 1'b0;
        dot_q  <= '0;
        norm_q <= '0;
        for (int k = 0; k < pal_pkg::NUM_CNT; k++) cnt_q[k] <= '0;
      end
    end
  end

  always_comb begin
    stat_o.pipe_busy = v1_q || v2_q;
    stat_o.skip      = (norm_q == '0);
    stat_o.query     = query;
    stat_o.loss_pos  = loss_pos_q;
    stat_o.div_done  = (dcnt_q == '0);
    stat_o.upd_done  = (ucnt_q >= idx_q) && !u1_q && !u2_q;
  end

  assign result_valid_o    = cmd_i.finish;
  assign predicted_label_o = pred_q;
  assign queried_o         = query_q;
  assign updated_o         = upd_q;
  assign skipped_o         = skip_q;
  assign true_positives_o  = cnt_q[pal_pkg::CNT_TP];
  assign true_negatives_o  = cnt_q[pal_pkg::CNT_TN];
  assign false_positives_o = cnt_q[pal_pkg::CNT_FP];
  assign false_negatives_o = cnt_q[pal_pkg::CNT_FN];
  assign query_total_o     = cnt_q[pal_pkg::CNT_QT];

endmodule
`default_nettype wire

### sv/pal_chk.sv
// Port-level checker for the PA learner, bound to the top level.
`default_nettype none
module pal_chk (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic cmd_i,
  input wire logic result_valid_o,
  input wire logic predicted_label_o,
  input wire logic queried_o,
  input wire logic updated_o,
  input wire logic skipped_o
);

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("result strobe longer than one cycle");

  a_skip_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && skipped_o |-> !predicted_label_o && !queried_o && !updated_o)
    else $error("skipped sample carries flags");

  a_upd_needs_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && updated_o |-> queried_o) else $error("update without query");

  a_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy) else $error("result shown while idle");

  a_clear_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && cmd_i |=> !result_valid_o && !busy) else $error("clear beat gave result");

endmodule

bind passive_aggressive_active_learner pal_chk u_pal_chk (.*);
`default_nettype wire
